// ===== rtl/gcb_pkg.sv =====
package gcb_pkg;

  localparam int MAX_CELLS_PER_AXIS = 4;
  localparam int NUM_AXES = 3;
  // doubled Q16.16 values plus grid extent and offsets fit in 37 signed bits
  localparam int CW = 37;
  // step counter runs 1 .. MAX_CELLS_PER_AXIS and one past it
  localparam int KW = $clog2(MAX_CELLS_PER_AXIS + 2);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int CELLS_W = 3;
  localparam int SIZE_W = 31;
  localparam int COORD_W = 2;
  localparam int INDEX_W = 6;

  typedef enum logic [2:0] {
    REG_CELLS_X = 3'd0,
    REG_CELLS_Y = 3'd1,
    REG_CELLS_Z = 3'd2,
    REG_SIZE_X  = 3'd3,
    REG_SIZE_Y  = 3'd4,
    REG_SIZE_Z  = 3'd5
  } reg_idx_t;

  localparam logic [CELLS_W-1:0] CELLS_RESET = 3'd4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd655360;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_GRID,
    ST_OFFS,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic               anchored;
  } box_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic               last_cell;
  } cell_word_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CELLS_W-1:0] cells;
    logic [NUM_AXES-1:0][SIZE_W-1:0]  size;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic ext;
    logic grid;
    logic offs;
    logic div;
    logic start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic empty;
    logic last;
    logic out_ready;
  } status_t;

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [CELLS_W-1:0] cells;
  } axis_res_t;

  function automatic logic [CELLS_W-1:0] cells_sat(input logic [CELLS_W-1:0] c);
    cells_sat = (c > CELLS_W'(MAX_CELLS_PER_AXIS)) ? CELLS_W'(MAX_CELLS_PER_AXIS) : c;
  endfunction

  function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] s);
    size_eff = (s == '0) ? SIZE_W'(1) : s;
  endfunction

endpackage

// ===== rtl/aabb_grid_cell_binning_unit.sv =====
// channel   | valid      | stall      | payload
// ----------+------------+------------+------------------------------
// box in    | box_valid  | box_stall  | box_word (corners, origin)
// cell out  | cell_valid | cell_stall | cell_word (index, last flag)
// config    | psel/penable/pwrite, pready always high, prdata on read
//
// after its accept a box goes through setup (extent, grid bounds,
// offsets, four compare steps of the per-axis quotient search, range check),
// then one cell per cycle while cell_stall is low; one box at a time.
// a box that misses the grid returns to idle after setup with no word.
// rst is synchronous; it restores the register defaults and drops cell_valid.
// a waiting output word holds while cell_stall is high; the scan waits for it.
module aabb_grid_cell_binning_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcb_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcb_pkg::DATA_W-1:0]  pwdata,
  output logic [gcb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        box_valid,
  output logic                        box_stall,
  input  gcb_pkg::box_word_t          box_word,
  output logic                        cell_valid,
  input  logic                        cell_stall,
  output gcb_pkg::cell_word_t         cell_word
);

  gcb_pkg::cfg_t    cfg;
  gcb_pkg::cmd_t    cmd;
  gcb_pkg::status_t st;

  gcb_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  gcb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .box_valid(box_valid), .st(st),
    .box_stall(box_stall), .cmd(cmd)
  );

  gcb_datapath u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .box_word(box_word),
    .cell_stall(cell_stall), .st(st), .cell_valid(cell_valid), .cell_word(cell_word)
  );

endmodule

// ===== rtl/gcb_regs.sv =====
module gcb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcb_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcb_pkg::DATA_W-1:0]  pwdata,
  output logic [gcb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output gcb_pkg::cfg_t               cfg
);

  gcb_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx = gcb_pkg::reg_idx_t'(paddr[gcb_pkg::ADDR_W-1:2]);
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < gcb_pkg::NUM_AXES; a++) begin
        cfg.cells[a] <= gcb_pkg::CELLS_RESET;
        cfg.size[a] <= gcb_pkg::SIZE_RESET;
      end
    end else if (wr) begin
      case (idx)
        gcb_pkg::REG_CELLS_X: cfg.cells[0] <= pwdata[gcb_pkg::CELLS_W-1:0];
        gcb_pkg::REG_CELLS_Y: cfg.cells[1] <= pwdata[gcb_pkg::CELLS_W-1:0];
        gcb_pkg::REG_CELLS_Z: cfg.cells[2] <= pwdata[gcb_pkg::CELLS_W-1:0];
        gcb_pkg::REG_SIZE_X:  cfg.size[0] <= pwdata[gcb_pkg::SIZE_W-1:0];
        gcb_pkg::REG_SIZE_Y:  cfg.size[1] <= pwdata[gcb_pkg::SIZE_W-1:0];
        gcb_pkg::REG_SIZE_Z:  cfg.size[2] <= pwdata[gcb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gcb_pkg::REG_CELLS_X: prdata = gcb_pkg::DATA_W'(cfg.cells[0]);
      gcb_pkg::REG_CELLS_Y: prdata = gcb_pkg::DATA_W'(cfg.cells[1]);
      gcb_pkg::REG_CELLS_Z: prdata = gcb_pkg::DATA_W'(cfg.cells[2]);
      gcb_pkg::REG_SIZE_X:  prdata = gcb_pkg::DATA_W'(cfg.size[0]);
      gcb_pkg::REG_SIZE_Y:  prdata = gcb_pkg::DATA_W'(cfg.size[1]);
      gcb_pkg::REG_SIZE_Z:  prdata = gcb_pkg::DATA_W'(cfg.size[2]);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/gcb_axis.sv =====
module gcb_axis (
  input  logic                            clk,
  input  gcb_pkg::cmd_t                   cmd,
  input  logic signed [31:0]              box_min,
  input  logic signed [31:0]              box_max,
  input  logic signed [31:0]              origin,
  input  logic                            anchored,
  input  logic [gcb_pkg::CELLS_W-1:0]     cells,
  input  logic [gcb_pkg::SIZE_W-1:0]      size,
  input  logic [gcb_pkg::KW-1:0]          k,
  output gcb_pkg::axis_res_t              res
);

  localparam int CW = gcb_pkg::CW;

  logic [gcb_pkg::CELLS_W-1:0] cz, cz_next;
  logic signed [CW-1:0]        sz2, sz2_next;
  logic signed [CW-1:0]        ext, ext_next;
  logic signed [CW-1:0]        gmin2, gmin2_next;
  logic signed [CW-1:0]        gmax2, gmax2_next;
  logic signed [CW-1:0]        rmin, rmax, m;
  logic                        miss_hi;
  logic [gcb_pkg::CELLS_W-1:0] lo_cnt;
  logic [gcb_pkg::COORD_W-1:0] hi_cnt;
  logic signed [CW-1:0]        s_w, o2, b2min, b2max;

  assign cz_next = gcb_pkg::cells_sat(cells);
  assign s_w = {{(CW-gcb_pkg::SIZE_W){1'b0}}, gcb_pkg::size_eff(size)};
  assign sz2_next = s_w <<< 1;

  // extent = size * cells with cells at most four
  always_comb begin
    case (cz_next)
      3'd1:    ext_next = s_w;
      3'd2:    ext_next = s_w <<< 1;
      3'd3:    ext_next = s_w + (s_w <<< 1);
      3'd4:    ext_next = s_w <<< 2;
      default: ext_next = '0;
    endcase
  end

  assign o2 = {{(CW-33){origin[31]}}, origin, 1'b0};
  assign b2min = {{(CW-33){box_min[31]}}, box_min, 1'b0};
  assign b2max = {{(CW-33){box_max[31]}}, box_max, 1'b0};

  assign gmin2_next = anchored ? '0 : (o2 - ext);
  assign gmax2_next = anchored ? (ext <<< 1) : (o2 + ext);

  always_ff @(posedge clk) begin
    if (cmd.ext) begin
      cz <= cz_next;
      sz2 <= sz2_next;
      ext <= ext_next;
    end
    if (cmd.grid) begin
      gmin2 <= gmin2_next;
      gmax2 <= gmax2_next;
    end
    if (cmd.offs) begin
      rmin <= b2min - gmin2;
      rmax <= b2max - gmin2;
      miss_hi <= gmax2 < b2min;
      m <= sz2;
      lo_cnt <= '0;
      hi_cnt <= '0;
    end
    // quotient search: one multiple of the doubled size per step
    if (cmd.div) begin
      if (rmin >= m) begin
        lo_cnt <= lo_cnt + 1'b1;
      end
      if ((rmax >= m) && (gcb_pkg::CELLS_W'(k) < cz)) begin
        hi_cnt <= hi_cnt + 1'b1;
      end
      m <= m + sz2;
    end
  end

  // negative rmax means the grid starts above the box
  assign res.empty = miss_hi | rmax[CW-1] | (cz == '0) | (lo_cnt > {1'b0, hi_cnt});
  assign res.lo = lo_cnt[gcb_pkg::COORD_W-1:0];
  assign res.hi = hi_cnt;
  assign res.cells = cz;

endmodule

// ===== rtl/gcb_datapath.sv =====
module gcb_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  gcb_pkg::cmd_t        cmd,
  input  gcb_pkg::cfg_t        cfg,
  input  gcb_pkg::box_word_t   box_word,
  input  logic                 cell_stall,
  output gcb_pkg::status_t     st,
  output logic                 cell_valid,
  output gcb_pkg::cell_word_t  cell_word
);

  gcb_pkg::box_word_t          box_q;
  gcb_pkg::axis_res_t          res [gcb_pkg::NUM_AXES];
  logic [gcb_pkg::KW-1:0]      k;
  logic [gcb_pkg::COORD_W-1:0] x, y, z;
  logic [7:0]                  idx_w;
  logic                        last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_q <= box_word;
    end
  end

  gcb_axis u_axis_x (
    .clk(clk), .cmd(cmd), .box_min(box_q.box_min_x), .box_max(box_q.box_max_x),
    .origin(box_q.origin_x), .anchored(box_q.anchored), .cells(cfg.cells[0]),
    .size(cfg.size[0]), .k(k), .res(res[0])
  );

  gcb_axis u_axis_y (
    .clk(clk), .cmd(cmd), .box_min(box_q.box_min_y), .box_max(box_q.box_max_y),
    .origin(box_q.origin_y), .anchored(box_q.anchored), .cells(cfg.cells[1]),
    .size(cfg.size[1]), .k(k), .res(res[1])
  );

  gcb_axis u_axis_z (
    .clk(clk), .cmd(cmd), .box_min(box_q.box_min_z), .box_max(box_q.box_max_z),
    .origin(box_q.origin_z), .anchored(box_q.anchored), .cells(cfg.cells[2]),
    .size(cfg.size[2]), .k(k), .res(res[2])
  );

  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      k <= gcb_pkg::KW'(1);
    end else if (cmd.div) begin
      k <= k + 1'b1;
    end
  end

  assign last = (x == res[0].hi) && (y == res[1].hi) && (z == res[2].hi);

  // z, y, x scan; x and y wrap back to their first cell, z only counts up
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x <= res[0].lo;
      y <= res[1].lo;
      z <= res[2].lo;
    end else if (cmd.emit) begin
      if (x == res[0].hi) begin
        x <= res[0].lo;
        if (y == res[1].hi) begin
          y <= res[1].lo;
          z <= z + 1'b1;
        end else begin
          y <= y + 1'b1;
        end
      end else begin
        x <= x + 1'b1;
      end
    end
  end

  assign idx_w = 8'(z) * 8'(res[0].cells) * 8'(res[1].cells)
               + 8'(y) * 8'(res[0].cells) + 8'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (cmd.emit) begin
      cell_valid <= 1'b1;
    end else if (!cell_stall) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_word.cell_index <= idx_w[gcb_pkg::INDEX_W-1:0];
      cell_word.last_cell <= last;
    end
  end

  assign st.div_last = (k == gcb_pkg::KW'(gcb_pkg::MAX_CELLS_PER_AXIS));
  assign st.empty = res[0].empty | res[1].empty | res[2].empty;
  assign st.last = last;
  assign st.out_ready = !cell_valid || !cell_stall;

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_ready)
    else $error("word emitted over a pending output word");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !st.empty)
    else $error("cell emitted for an empty range");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div |-> (k >= gcb_pkg::KW'(1)) && (k <= gcb_pkg::KW'(gcb_pkg::MAX_CELLS_PER_AXIS)))
    else $error("division step counter out of range");

endmodule

// ===== rtl/gcb_ctrl.sv =====
module gcb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  input  gcb_pkg::status_t  st,
  output logic              box_stall,
  output gcb_pkg::cmd_t     cmd
);

  gcb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gcb_pkg::ST_IDLE:  if (box_valid) state_next = gcb_pkg::ST_EXT;
      gcb_pkg::ST_EXT:   state_next = gcb_pkg::ST_GRID;
      gcb_pkg::ST_GRID:  state_next = gcb_pkg::ST_OFFS;
      gcb_pkg::ST_OFFS:  state_next = gcb_pkg::ST_DIV;
      gcb_pkg::ST_DIV:   if (st.div_last) state_next = gcb_pkg::ST_CHECK;
      gcb_pkg::ST_CHECK: state_next = st.empty ? gcb_pkg::ST_IDLE : gcb_pkg::ST_EMIT;
      gcb_pkg::ST_EMIT:  if (st.out_ready && st.last) state_next = gcb_pkg::ST_IDLE;
      default:           state_next = gcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    box_stall = 1'b1;
    case (state)
      gcb_pkg::ST_IDLE: begin
        box_stall = 1'b0;
        cmd.load = box_valid;
      end
      gcb_pkg::ST_EXT:   cmd.ext = 1'b1;
      gcb_pkg::ST_GRID:  cmd.grid = 1'b1;
      gcb_pkg::ST_OFFS:  cmd.offs = 1'b1;
      gcb_pkg::ST_DIV:   cmd.div = 1'b1;
      gcb_pkg::ST_CHECK: cmd.start = 1'b1;
      gcb_pkg::ST_EMIT:  cmd.emit = st.out_ready;
      default: ;
    endcase
  end

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (state == gcb_pkg::ST_IDLE && box_valid) |=> state == gcb_pkg::ST_EXT)
    else $error("accepted word did not start setup");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    (state == gcb_pkg::ST_CHECK && st.empty) |=> state == gcb_pkg::ST_IDLE)
    else $error("empty box did not return to idle");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.last) |=> state == gcb_pkg::ST_IDLE)
    else $error("scan continued past the last cell");

endmodule
